FILE: hw/rtl/dnsx_pkg.sv
// Shared types and constants for the DNS response address extractor.
// No dependencies; the parser, top level and checker import this package.
`default_nettype none

package dnsx_pkg;

   // Reset value of the expected transaction id register
   localparam logic [15:0] QUERY_ID_RESET = 16'h55AA;

   // Record data length that marks an IPv4 address record
   localparam logic [15:0] RDATA_IPV4_LEN = 16'h0004;

   // Byte offsets within the fixed header, the question tail and the answer record
   localparam int unsigned OFFSET_W = 4;
   localparam logic [OFFSET_W-1:0] HDR_ID_HI   = 4'd0;
   localparam logic [OFFSET_W-1:0] HDR_ID_LO   = 4'd1;
   localparam logic [OFFSET_W-1:0] HDR_FLAGS   = 4'd2;
   localparam logic [OFFSET_W-1:0] HDR_QD_HI   = 4'd4;
   localparam logic [OFFSET_W-1:0] HDR_QD_LO   = 4'd5;
   localparam logic [OFFSET_W-1:0] HDR_AN_HI   = 4'd6;
   localparam logic [OFFSET_W-1:0] HDR_AN_LO   = 4'd7;
   localparam logic [OFFSET_W-1:0] HDR_LAST    = 4'd11;
   localparam logic [OFFSET_W-1:0] QTAIL_LAST  = 4'd3;
   localparam logic [OFFSET_W-1:0] ANS_RDLEN_HI = 4'd10;
   localparam logic [OFFSET_W-1:0] ANS_RDLEN_LO = 4'd11;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ID       = 3'd1,
      ST_NOTRESP  = 3'd2,
      ST_NOANSWER = 3'd3,
      ST_TRUNC    = 3'd4
   } status_type;

   // Parser phases, one-hot
   typedef enum logic [7:0] {
      PH_HEADER   = 8'b0000_0001,
      PH_QLEN     = 8'b0000_0010,
      PH_QLABEL   = 8'b0000_0100,
      PH_QTAIL    = 8'b0000_1000,
      PH_AFIXED   = 8'b0001_0000,
      PH_ACAPTURE = 8'b0010_0000,
      PH_ASKIP    = 8'b0100_0000,
      PH_DONE     = 8'b1000_0000
   } phase_type;

   // One result item as it leaves the parser
   typedef struct packed {
      status_type  status;
      logic        address_found;
      logic [31:0] ipv4_address;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dnsx_channels.sv
// Channel interfaces of the DNS response address extractor: request bytes,
// result items and register writes. Standalone; no package needed.
`default_nettype none

// Packet byte channel
interface dnsx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// Result channel
interface dnsx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        address_found;
   logic [31:0] ipv4_address;
   modport source (output valid, status, address_found, ipv4_address, input ready);
   modport sink   (input valid, status, address_found, ipv4_address, output ready);
endinterface

// Register write channel carrying the expected transaction id
interface dnsx_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] query_id;
   modport source (output valid, query_id, input ready);
   modport sink   (input valid, query_id, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dnsx_parser.sv
// Byte-wise DNS response parser: header checks, question skip, answer walk
// and IPv4 capture. Depends on dnsx_pkg.
`default_nettype none

module dnsx_parser import dnsx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] query_id,
   input  logic        take,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output result_type  result
);

   phase_type             phase_ff, phase_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [15:0]           questions_ff, questions_in;
   logic [15:0]           answers_ff, answers_in;
   logic [7:0]            label_ff, label_in;
   logic [15:0]           rdata_ff, rdata_in;
   logic [31:0]           addr_ff, addr_in;
   logic                  addr_valid_ff, addr_valid_in;
   status_type            error_ff, error_in;

   logic [15:0]           answers_dec;
   logic [15:0]           rdata_dec;
   logic [15:0]           questions_dec;
   logic [15:0]           rdlen;
   logic [OFFSET_W-1:0]   offset_inc;

   assign answers_dec   = answers_ff - 16'd1;
   assign rdata_dec     = rdata_ff - 16'd1;
   assign questions_dec = questions_ff - 16'd1;
   assign rdlen         = {rdata_ff[15:8], data_byte};
   assign offset_inc    = offset_ff + 1'b1;

   // Advance the parse by one byte; a latched error freezes everything
   always_comb begin
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      questions_in  = questions_ff;
      answers_in    = answers_ff;
      label_in      = label_ff;
      rdata_in      = rdata_ff;
      addr_in       = addr_ff;
      addr_valid_in = addr_valid_ff;
      error_in      = error_ff;
      if (error_ff == ST_OK) begin
         case (phase_ff)
            PH_HEADER: begin
               case (offset_ff)
                  HDR_ID_HI: if (data_byte != query_id[15:8]) error_in = ST_ID;
                  HDR_ID_LO: if (data_byte != query_id[7:0]) error_in = ST_ID;
                  HDR_FLAGS: if (!data_byte[7]) error_in = ST_NOTRESP;
                  HDR_QD_HI: questions_in = {data_byte, 8'h00};
                  HDR_QD_LO: questions_in = {questions_ff[15:8], data_byte};
                  HDR_AN_HI: answers_in = {data_byte, 8'h00};
                  HDR_AN_LO: begin
                     answers_in = {answers_ff[15:8], data_byte};
                     if ({answers_ff[15:8], data_byte} == 16'd0) error_in = ST_NOANSWER;
                  end
                  default: ;
               endcase
               if (offset_ff == HDR_LAST) begin
                  offset_in = '0;
                  phase_in  = (questions_ff == 16'd0) ? PH_AFIXED : PH_QLEN;
               end else begin
                  offset_in = offset_inc;
               end
            end
            PH_QLEN: begin
               if (data_byte == 8'd0) begin
                  offset_in = '0;
                  phase_in  = PH_QTAIL;
               end else begin
                  label_in = data_byte;
                  phase_in = PH_QLABEL;
               end
            end
            PH_QLABEL: begin
               label_in = label_ff - 8'd1;
               if (label_ff == 8'd1) phase_in = PH_QLEN;
            end
            PH_QTAIL: begin
               offset_in = offset_inc;
               if (offset_ff == QTAIL_LAST) begin
                  questions_in = questions_dec;
                  offset_in    = '0;
                  phase_in     = (questions_dec == 16'd0) ? PH_AFIXED : PH_QLEN;
               end
            end
            PH_AFIXED: begin
               if (offset_ff == ANS_RDLEN_HI) begin
                  rdata_in  = {data_byte, 8'h00};
                  offset_in = offset_inc;
               end else if (offset_ff == ANS_RDLEN_LO) begin
                  rdata_in  = rdlen;
                  offset_in = '0;
                  if (rdlen == 16'd0) begin
                     answers_in = answers_dec;
                     phase_in   = (answers_dec == 16'd0) ? PH_DONE : PH_AFIXED;
                  end else if (rdlen == RDATA_IPV4_LEN && !addr_valid_ff) begin
                     phase_in = PH_ACAPTURE;
                  end else begin
                     phase_in = PH_ASKIP;
                  end
               end else begin
                  offset_in = offset_inc;
               end
            end
            PH_ACAPTURE: begin
               addr_in  = {addr_ff[23:0], data_byte};
               rdata_in = rdata_dec;
               if (rdata_dec == 16'd0) begin
                  addr_valid_in = 1'b1;
                  answers_in    = answers_dec;
                  offset_in     = '0;
                  phase_in      = (answers_dec == 16'd0) ? PH_DONE : PH_AFIXED;
               end
            end
            PH_ASKIP: begin
               rdata_in = rdata_dec;
               if (rdata_dec == 16'd0) begin
                  answers_in = answers_dec;
                  offset_in  = '0;
                  phase_in   = (answers_dec == 16'd0) ? PH_DONE : PH_AFIXED;
               end
            end
            default: ;
         endcase
      end
   end

   // Form the result from the state after this byte
   always_comb begin
      if (error_in != ST_OK) begin
         result.status = error_in;
      end else if (phase_in != PH_DONE) begin
         result.status = ST_TRUNC;
      end else begin
         result.status = ST_OK;
      end
      result.address_found = addr_valid_in;
      result.ipv4_address  = addr_valid_in ? addr_in : 32'd0;
   end

   // Hold parser state; drop it after the last byte of a packet
   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         phase_ff      <= PH_HEADER;
         offset_ff     <= '0;
         questions_ff  <= '0;
         answers_ff    <= '0;
         label_ff      <= '0;
         rdata_ff      <= '0;
         addr_valid_ff <= 1'b0;
         error_ff      <= ST_OK;
      end else if (take) begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         questions_ff  <= questions_in;
         answers_ff    <= answers_in;
         label_ff      <= label_in;
         rdata_ff      <= rdata_in;
         addr_valid_ff <= addr_valid_in;
         error_ff      <= error_in;
      end
   end

   // Shift in address bytes
   always_ff @(posedge clock) begin
      if (take) begin
         addr_ff <= addr_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dns_response_address_extractor.sv
// Top level of the DNS response address extractor: channels, expected id
// register and result register. Depends on dnsx_pkg, dnsx_channels, dnsx_parser.
//
// Usage:
//   req_chan carries a DNS response one byte per item; last_byte marks the
//   final byte of a packet. rsp_chan returns one item per packet: status
//   (ok, id mismatch, not a response, no answers, truncated), address_found
//   and the first four-byte answer record as ipv4_address (zero if none).
//   csr_chan writes the expected transaction id; it is always ready and
//   should be written only while no packet is in progress.
// Timing:
//   One byte is accepted per cycle unless stalled. The result appears on
//   rsp_chan in the cycle after the last byte is accepted; the parser updates
//   a small set of counters per byte between its state and result registers.
// Reset:
//   Synchronous reset clears the parser, empties the result register and
//   loads the expected id with 0x55AA.
// Stall:
//   A held result does not block bytes of the next packet; only a new last
//   byte waits (req_chan.ready low) while an untaken result occupies the
//   result register and rsp_chan.ready is low.
`default_nettype none

module dns_response_address_extractor import dnsx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dnsx_req_if.sink   req_chan,
   dnsx_rsp_if.source rsp_chan,
   dnsx_csr_if.sink   csr_chan
);

   logic [15:0] query_id_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_result_ff;
   result_type  parse_result;
   logic        take;
   logic        slot_free;

   // Accept a byte unless it would finish a packet into a full result slot
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = slot_free || !req_chan.last_byte;
   assign take           = req_chan.valid && req_chan.ready;

   // Register write port
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_id_ff <= QUERY_ID_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         query_id_ff <= csr_chan.query_id;
      end
   end

   dnsx_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .query_id  (query_id_ff),
      .take      (take),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .result    (parse_result)
   );

   // Load the result on the last byte; hold it until taken
   always_comb begin
      if (take && req_chan.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_chan.last_byte) begin
         rsp_result_ff <= parse_result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_result_ff.status;
   assign rsp_chan.address_found = rsp_result_ff.address_found;
   assign rsp_chan.ipv4_address  = rsp_result_ff.ipv4_address;

endmodule

`default_nettype wire

FILE: hw/rtl/dnsx_checker.sv
// Port-level checks for the DNS response address extractor, bound to the
// top level. Depends on dnsx_pkg and dns_response_address_extractor.
`default_nettype none

module dnsx_checker import dnsx_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_address_found,
   input logic [31:0] rsp_ipv4_address
);

   // A waiting result stays and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_address_found) && $stable(rsp_ipv4_address))
      else $error("result dropped or changed while stalled");

   // A new result only follows an accepted last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(rsp_valid) || $past(req_valid && req_ready && req_last_byte))
      else $error("result without a last byte");

   // No address is reported without a captured record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_address_found |-> rsp_ipv4_address == 32'd0)
      else $error("address shown without capture");

   // Header errors come before any answer, so they never carry an address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_found |-> rsp_status == ST_OK || rsp_status == ST_TRUNC)
      else $error("address with a header error");

   // Only a last byte stalls, and only behind an untaken result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && req_last_byte)
      else $error("input stalled without cause");

endmodule

bind dns_response_address_extractor dnsx_checker u_dnsx_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_last_byte     (req_chan.last_byte),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_address_found (rsp_chan.address_found),
   .rsp_ipv4_address  (rsp_chan.ipv4_address)
);

`default_nettype wire
